// ----- hdl/dsfr_pkg.sv -----
package dsfr_pkg;

    localparam int FIFO_DEPTH_DEF = 64;
    localparam int TIME_W     = 32;
    localparam int ITER_W     = 32;
    localparam int PAYLOAD_W  = 64;
    localparam int DUE_W      = 34;
    localparam int PERIOD_W   = 12;
    localparam int CNT_W      = 32;
    localparam int NUM_STATS  = 7;
    localparam int DEPTH_W    = 7;
    localparam int DIV_STEPS  = 32;
    localparam int STEP_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    localparam logic [PERIOD_W-1:0] PERIOD_250  = PERIOD_W'(1000000 / 250);
    localparam logic [PERIOD_W-1:0] PERIOD_500  = PERIOD_W'(1000000 / 500);
    localparam logic [PERIOD_W-1:0] PERIOD_1000 = PERIOD_W'(1000000 / 1000);

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 1'b1;

    localparam logic [1:0] RATE_250  = 2'd0;
    localparam logic [1:0] RATE_500  = 2'd1;
    localparam logic [1:0] RATE_1000 = 2'd2;

    localparam logic [2:0] ST_ATTEMPTED = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_REGRESSED = 3'd3;
    localparam logic [2:0] ST_SKIPPED   = 3'd4;
    localparam logic [2:0] ST_MISSED    = 3'd5;
    localparam logic [2:0] ST_ACCEPTED  = 3'd6;

    typedef enum logic [1:0] {
        OP_CAPTURE = 2'd0,
        OP_POP     = 2'd1,
        OP_STAT    = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CAP_ACCEPTED  = 3'd0,
        CAP_INACTIVE  = 3'd1,
        CAP_INVALID   = 3'd2,
        CAP_REGRESSED = 3'd3,
        CAP_SKIPPED   = 3'd4,
        CAP_FULL      = 3'd5
    } t_cap_status;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
    } t_dp_stat;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [TIME_W-1:0]    time_us;
        logic [ITER_W-1:0]    iteration;
        logic [CNT_W-1:0]     dropped;
    } t_entry;

endpackage

// ----- hdl/decimating_sample_fifo_recorder_unit.sv -----
// Sample recorder with rate decimation, a ring queue and saturating statistics.
// An item is taken when i_start is high and o_busy low; its result appears for
// one cycle with o_valid and the receiver cannot stall it, so it must sample
// every strobe. A pop, a statistic read or a capture that is not due is
// evaluated and then strobed; a due capture also runs the bit-serial divider
// that counts missed periods (one quotient bit per cycle) before it finishes.
// Configuration is taken when o_busy is low.
module decimating_sample_fifo_recorder_unit #(
    parameter int FIFO_DEPTH = dsfr_pkg::FIFO_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [1:0]                         i_opcode,
    input  logic [dsfr_pkg::TIME_W-1:0]        i_time_us,
    input  logic [dsfr_pkg::ITER_W-1:0]        i_iteration,
    input  logic                               i_sample_ok,
    input  logic [dsfr_pkg::PAYLOAD_W-1:0]     i_payload,
    input  logic [2:0]                         i_stat_select,
    output logic                               o_valid,
    output logic [2:0]                         o_status,
    output logic                               o_pop_valid,
    output logic [dsfr_pkg::PAYLOAD_W-1:0]     o_pop_payload,
    output logic [dsfr_pkg::TIME_W-1:0]        o_pop_time,
    output logic [dsfr_pkg::ITER_W-1:0]        o_pop_iteration,
    output logic [dsfr_pkg::CNT_W-1:0]         o_pop_dropped,
    output logic [dsfr_pkg::DEPTH_W-1:0]       o_depth,
    output logic [dsfr_pkg::CNT_W-1:0]         o_stat_value,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dsfr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dsfr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import dsfr_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     busy;

    assign o_busy      = busy;
    assign o_cfg_ready = !busy;

    dsfr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_dp_stat (dp_stat),
        .o_dp_cmd  (dp_cmd),
        .o_busy    (busy),
        .o_valid   (o_valid)
    );

    dsfr_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp_cmd        (dp_cmd),
        .o_dp_stat       (dp_stat),
        .i_cfg_we        (i_cfg_valid && !busy),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_time_us       (i_time_us),
        .i_iteration     (i_iteration),
        .i_sample_ok     (i_sample_ok),
        .i_payload       (i_payload),
        .i_stat_select   (i_stat_select),
        .o_status        (o_status),
        .o_pop_valid     (o_pop_valid),
        .o_pop_payload   (o_pop_payload),
        .o_pop_time      (o_pop_time),
        .o_pop_iteration (o_pop_iteration),
        .o_pop_dropped   (o_pop_dropped),
        .o_depth         (o_depth),
        .o_stat_value    (o_stat_value)
    );

endmodule

// ----- hdl/dsfr_ctrl.sv -----
module dsfr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  dsfr_pkg::t_dp_stat i_dp_stat,
    output dsfr_pkg::t_dp_cmd  o_dp_cmd,
    output logic               o_busy,
    output logic               o_valid
);
    import dsfr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_FINISH,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic              r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_step <= '0;
                    if (i_dp_stat.need_div) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_DONE;
                        r_valid <= 1'b1;
                    end
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(DIV_STEPS - 1)) r_state <= S_FINISH;
                end
                S_FINISH: begin
                    r_state <= S_DONE;
                    r_valid <= 1'b1;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_dp_cmd.load     = (r_state == S_IDLE) && i_start;
        o_dp_cmd.eval     = (r_state == S_EVAL);
        o_dp_cmd.div_step = (r_state == S_DIV);
        o_dp_cmd.finish   = (r_state == S_FINISH);
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

// ----- hdl/dsfr_dp.sv -----
module dsfr_dp #(
    parameter int FIFO_DEPTH = dsfr_pkg::FIFO_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dsfr_pkg::t_dp_cmd                  i_dp_cmd,
    output dsfr_pkg::t_dp_stat                 o_dp_stat,
    input  logic                               i_cfg_we,
    input  logic [dsfr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dsfr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [1:0]                         i_opcode,
    input  logic [dsfr_pkg::TIME_W-1:0]        i_time_us,
    input  logic [dsfr_pkg::ITER_W-1:0]        i_iteration,
    input  logic                               i_sample_ok,
    input  logic [dsfr_pkg::PAYLOAD_W-1:0]     i_payload,
    input  logic [2:0]                         i_stat_select,
    output logic [2:0]                         o_status,
    output logic                               o_pop_valid,
    output logic [dsfr_pkg::PAYLOAD_W-1:0]     o_pop_payload,
    output logic [dsfr_pkg::TIME_W-1:0]        o_pop_time,
    output logic [dsfr_pkg::ITER_W-1:0]        o_pop_iteration,
    output logic [dsfr_pkg::CNT_W-1:0]         o_pop_dropped,
    output logic [dsfr_pkg::DEPTH_W-1:0]       o_depth,
    output logic [dsfr_pkg::CNT_W-1:0]         o_stat_value
);
    import dsfr_pkg::*;

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] SAT = '1;

    t_entry r_mem [FIFO_DEPTH];
    t_entry r_rd_data;

    logic [AW-1:0]       r_wptr, r_rptr;
    logic [FW-1:0]       r_fill;
    logic [TIME_W-1:0]   r_prev_time;
    logic [ITER_W-1:0]   r_prev_iter;
    logic [DUE_W-1:0]    r_due;
    logic                r_seen;
    logic [CNT_W-1:0]    r_cnt [NUM_STATS];
    logic [PERIOD_W-1:0] r_period;
    logic                r_enable;
    logic [1:0]          r_rate;

    t_op                 r_op;
    logic [TIME_W-1:0]   r_t;
    logic [ITER_W-1:0]   r_it;
    logic                r_ok;
    logic [PAYLOAD_W-1:0] r_pl;
    logic [2:0]          r_sel;

    t_cap_status         r_status;
    logic                r_pop_valid;
    logic [CNT_W-1:0]    r_stat_value;

    logic [TIME_W-1:0]   r_quot;
    logic [PERIOD_W-1:0] r_rem;

    logic                regressed, too_early;
    logic [DUE_W-1:0]    due_eff;
    logic [PERIOD_W:0]   trial;
    logic [CNT_W:0]      missed_sum;
    logic [PERIOD_W-1:0] n_period;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == SAT) ? SAT : c + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        ptr_next = (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        due_eff   = r_seen ? r_due : {{(DUE_W-TIME_W){1'b0}}, r_t};
        regressed = r_seen && ((r_t < r_prev_time) || (r_it < r_prev_iter));
        too_early = {{(DUE_W-TIME_W){1'b0}}, r_t} < due_eff;
        o_dp_stat.need_div = (r_op == OP_CAPTURE) && r_enable && r_ok && !regressed
                             && !too_early;
        trial      = {r_rem, r_quot[TIME_W-1]};
        missed_sum = {1'b0, r_cnt[ST_MISSED]} + {1'b0, r_quot};
        case (r_rate)
            RATE_250:  n_period = PERIOD_250;
            RATE_500:  n_period = PERIOD_500;
            default:   n_period = PERIOD_1000;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.finish && !(r_fill >= FW'(FIFO_DEPTH))) begin
            r_mem[r_wptr] <= '{payload: r_pl, time_us: r_t, iteration: r_it,
                               dropped: r_cnt[ST_DROPPED]};
        end
        if (i_dp_cmd.eval && r_op == OP_POP) r_rd_data <= r_mem[r_rptr];
        if (i_dp_cmd.load) begin
            r_op  <= t_op'(i_opcode);
            r_t   <= i_time_us;
            r_it  <= i_iteration;
            r_ok  <= i_sample_ok;
            r_pl  <= i_payload;
            r_sel <= i_stat_select;
        end
        if (i_dp_cmd.eval) begin
            r_quot <= r_t - due_eff[TIME_W-1:0];
            r_rem  <= '0;
        end else if (i_dp_cmd.div_step) begin
            if (trial >= {1'b0, r_period}) begin
                r_rem <= PERIOD_W'(trial - {1'b0, r_period});
                r_quot <= {r_quot[TIME_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[PERIOD_W-1:0];
                r_quot <= {r_quot[TIME_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr       <= '0;
            r_rptr       <= '0;
            r_fill       <= '0;
            r_prev_time  <= '0;
            r_prev_iter  <= '0;
            r_due        <= '0;
            r_seen       <= 1'b0;
            for (int k = 0; k < NUM_STATS; k++) r_cnt[k] <= '0;
            r_period     <= PERIOD_250;
            r_enable     <= 1'b0;
            r_rate       <= RATE_250;
            r_status     <= CAP_ACCEPTED;
            r_pop_valid  <= 1'b0;
            r_stat_value <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_RATE) begin
                    r_rate <= i_cfg_data;
                end else if (!i_cfg_data[0]) begin
                    r_enable <= 1'b0;
                end else if (!r_enable && r_fill == '0 && r_rate != 2'd3) begin
                    r_wptr      <= '0;
                    r_rptr      <= '0;
                    r_prev_time <= '0;
                    r_prev_iter <= '0;
                    r_due       <= '0;
                    r_seen      <= 1'b0;
                    for (int k = 0; k < NUM_STATS; k++) r_cnt[k] <= '0;
                    r_period    <= n_period;
                    r_enable    <= 1'b1;
                end
            end
            if (i_dp_cmd.load) begin
                r_status     <= CAP_ACCEPTED;
                r_pop_valid  <= 1'b0;
                r_stat_value <= '0;
            end
            if (i_dp_cmd.eval) begin
                case (r_op)
                    OP_CAPTURE: begin
                        if (!r_enable) begin
                            r_status <= CAP_INACTIVE;
                        end else begin
                            r_cnt[ST_ATTEMPTED] <= sat_inc(r_cnt[ST_ATTEMPTED]);
                            if (!r_ok) begin
                                r_cnt[ST_INVALID] <= sat_inc(r_cnt[ST_INVALID]);
                                r_cnt[ST_DROPPED] <= sat_inc(r_cnt[ST_DROPPED]);
                                r_status <= CAP_INVALID;
                            end else if (regressed) begin
                                r_cnt[ST_REGRESSED] <= sat_inc(r_cnt[ST_REGRESSED]);
                                r_cnt[ST_DROPPED]   <= sat_inc(r_cnt[ST_DROPPED]);
                                r_status <= CAP_REGRESSED;
                            end else begin
                                r_prev_time <= r_t;
                                r_prev_iter <= r_it;
                                r_seen      <= 1'b1;
                                r_due       <= due_eff;
                                if (too_early) begin
                                    r_cnt[ST_SKIPPED] <= sat_inc(r_cnt[ST_SKIPPED]);
                                    r_status <= CAP_SKIPPED;
                                end
                            end
                        end
                    end
                    OP_POP: begin
                        if (r_fill != '0) begin
                            r_pop_valid <= 1'b1;
                            r_rptr      <= ptr_next(r_rptr);
                            r_fill      <= r_fill - 1'b1;
                        end
                    end
                    OP_STAT: begin
                        if (r_sel < 3'(NUM_STATS)) r_stat_value <= r_cnt[r_sel];
                    end
                    default: ;
                endcase
            end
            if (i_dp_cmd.finish) begin
                r_cnt[ST_MISSED] <= missed_sum[CNT_W] ? SAT : missed_sum[CNT_W-1:0];
                r_due <= {{(DUE_W-TIME_W){1'b0}}, r_t} - {{(DUE_W-PERIOD_W){1'b0}}, r_rem}
                         + {{(DUE_W-PERIOD_W){1'b0}}, r_period};
                if (r_fill >= FW'(FIFO_DEPTH)) begin
                    r_cnt[ST_DROPPED] <= sat_inc(r_cnt[ST_DROPPED]);
                    r_status <= CAP_FULL;
                end else begin
                    r_wptr <= ptr_next(r_wptr);
                    r_fill <= r_fill + 1'b1;
                    r_cnt[ST_ACCEPTED] <= sat_inc(r_cnt[ST_ACCEPTED]);
                    r_status <= CAP_ACCEPTED;
                end
            end
        end
    end

    assign o_status        = r_status;
    assign o_pop_valid     = r_pop_valid;
    assign o_pop_payload   = r_pop_valid ? r_rd_data.payload : '0;
    assign o_pop_time      = r_pop_valid ? r_rd_data.time_us : '0;
    assign o_pop_iteration = r_pop_valid ? r_rd_data.iteration : '0;
    assign o_pop_dropped   = r_pop_valid ? r_rd_data.dropped : '0;
    assign o_depth         = DEPTH_W'(r_fill);
    assign o_stat_value    = r_stat_value;

endmodule

// ----- tb/dsfr_checker.sv -----
`timescale 1ns / 1ps

module dsfr_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [1:0]                     i_opcode,
    input  logic [dsfr_pkg::TIME_W-1:0]    i_time_us,
    input  logic [dsfr_pkg::ITER_W-1:0]    i_iteration,
    input  logic                           i_sample_ok,
    input  logic [dsfr_pkg::PAYLOAD_W-1:0] i_payload,
    input  logic [2:0]                     i_stat_select,
    input  logic                           i_valid,
    input  logic [2:0]                     i_status,
    input  logic                           i_pop_valid,
    input  logic [dsfr_pkg::PAYLOAD_W-1:0] i_pop_payload,
    input  logic [dsfr_pkg::TIME_W-1:0]    i_pop_time,
    input  logic [dsfr_pkg::ITER_W-1:0]    i_pop_iteration,
    input  logic [dsfr_pkg::CNT_W-1:0]     i_pop_dropped,
    input  logic [dsfr_pkg::DEPTH_W-1:0]   i_depth,
    input  logic [dsfr_pkg::CNT_W-1:0]     i_stat_value,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [dsfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dsfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_errors
);
    import dsfr_pkg::*;

    typedef struct {
        logic [2:0]           status;
        logic                 pop_valid;
        logic [PAYLOAD_W-1:0] payload;
        logic [TIME_W-1:0]    time_us;
        logic [ITER_W-1:0]    iteration;
        logic [CNT_W-1:0]     dropped;
        logic [DEPTH_W-1:0]   depth;
        logic [CNT_W-1:0]     stat_value;
    } t_outcome;

    t_entry               ring [FIFO_DEPTH_DEF];
    int unsigned          wr_idx, rd_idx, fill;
    logic [TIME_W-1:0]    prev_t;
    logic [ITER_W-1:0]    last_iter;
    logic [DUE_W-1:0]     sched_due;
    logic                 got_sample;
    logic [CNT_W-1:0]     counters [NUM_STATS];
    logic [31:0]          period;
    logic                 enabled;
    logic [1:0]           rate;
    t_outcome             pending [$];

    function automatic void bump(int idx, longint unsigned n);
        longint unsigned room;
        room = 64'hFFFF_FFFF - 64'(counters[idx]);
        counters[idx] = (n > room) ? 32'hFFFF_FFFF : counters[idx] + n[31:0];
    endfunction

    function automatic void clear_state();
        wr_idx = 0;
        rd_idx = 0;
        fill = 0;
        prev_t = '0;
        last_iter = '0;
        sched_due = '0;
        got_sample = 1'b0;
        for (int k = 0; k < NUM_STATS; k++) counters[k] = '0;
    endfunction

    function automatic logic [2:0] capture_outcome();
        longint unsigned missed;
        if (!enabled) return CAP_INACTIVE;
        bump(ST_ATTEMPTED, 1);
        if (!i_sample_ok) begin
            bump(ST_INVALID, 1);
            bump(ST_DROPPED, 1);
            return CAP_INVALID;
        end
        if (got_sample && (i_time_us < prev_t || i_iteration < last_iter)) begin
            bump(ST_REGRESSED, 1);
            bump(ST_DROPPED, 1);
            return CAP_REGRESSED;
        end
        prev_t = i_time_us;
        last_iter = i_iteration;
        if (!got_sample) begin
            sched_due = DUE_W'(i_time_us);
            got_sample = 1'b1;
        end
        if (DUE_W'(i_time_us) < sched_due) begin
            bump(ST_SKIPPED, 1);
            return CAP_SKIPPED;
        end
        missed = (64'(i_time_us) - 64'(sched_due)) / 64'(period);
        bump(ST_MISSED, missed);
        sched_due = DUE_W'(64'(sched_due) + (missed + 1) * 64'(period));
        if (fill >= FIFO_DEPTH_DEF) begin
            bump(ST_DROPPED, 1);
            return CAP_FULL;
        end
        ring[wr_idx] = '{i_payload, i_time_us, i_iteration, counters[ST_DROPPED]};
        wr_idx = (wr_idx + 1) % FIFO_DEPTH_DEF;
        fill++;
        bump(ST_ACCEPTED, 1);
        return CAP_ACCEPTED;
    endfunction

    function automatic t_outcome predict_item();
        t_outcome r;
        r = '{default: '0};
        case (t_op'(i_opcode))
            OP_CAPTURE: r.status = capture_outcome();
            OP_POP: begin
                if (fill != 0) begin
                    r.pop_valid = 1'b1;
                    r.payload = ring[rd_idx].payload;
                    r.time_us = ring[rd_idx].time_us;
                    r.iteration = ring[rd_idx].iteration;
                    r.dropped = ring[rd_idx].dropped;
                    rd_idx = (rd_idx + 1) % FIFO_DEPTH_DEF;
                    fill--;
                end
            end
            OP_STAT: if (i_stat_select < NUM_STATS) r.stat_value = counters[i_stat_select];
            default: ;
        endcase
        r.depth = DEPTH_W'(fill);
        return r;
    endfunction

    function automatic void apply_config();
        if (i_cfg_index == CFG_ENABLE) begin
            if (!i_cfg_data[0]) begin
                enabled = 1'b0;
            end else if (!enabled && fill == 0 && rate <= RATE_1000) begin
                clear_state();
                period = (rate == RATE_250) ? 32'(PERIOD_250) :
                         (rate == RATE_500) ? 32'(PERIOD_500) : 32'(PERIOD_1000);
                enabled = 1'b1;
            end
        end else begin
            rate = i_cfg_data;
        end
    endfunction

    task automatic compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            o_errors++;
            $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome e;
        if (!i_rst_n) begin
            clear_state();
            period = 32'(PERIOD_250);
            enabled = 1'b0;
            rate = RATE_250;
            pending.delete();
        end else begin
            if (i_valid) begin
                if (pending.size() == 0) begin
                    o_errors++;
                    $display("%0t unexpected result, expected none, actual status %h",
                             $time, i_status);
                end else begin
                    e = pending.pop_front();
                    compare("status", 64'(e.status), 64'(i_status));
                    compare("pop_valid", 64'(e.pop_valid), 64'(i_pop_valid));
                    compare("pop_payload", e.payload, i_pop_payload);
                    compare("pop_time", 64'(e.time_us), 64'(i_pop_time));
                    compare("pop_iteration", 64'(e.iteration), 64'(i_pop_iteration));
                    compare("pop_dropped", 64'(e.dropped), 64'(i_pop_dropped));
                    compare("depth", 64'(e.depth), 64'(i_depth));
                    compare("stat_value", 64'(e.stat_value), 64'(i_stat_value));
                end
            end
            if (i_cfg_valid && i_cfg_ready) apply_config();
            if (i_start && !i_busy) pending.push_back(predict_item());
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import dsfr_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            opcode = OP_NOP;
    logic [TIME_W-1:0]     time_us = '0;
    logic [ITER_W-1:0]     iteration = '0;
    logic                  sample_ok = 1'b0;
    logic [PAYLOAD_W-1:0]  payload = '0;
    logic [2:0]            stat_select = '0;
    logic                  res_valid;
    logic [2:0]            status;
    logic                  pop_valid;
    logic [PAYLOAD_W-1:0]  pop_payload;
    logic [TIME_W-1:0]     pop_time;
    logic [ITER_W-1:0]     pop_iteration;
    logic [CNT_W-1:0]      pop_dropped;
    logic [DEPTH_W-1:0]    depth;
    logic [CNT_W-1:0]      stat_value;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    errors;
    int                    issued = 0;
    int                    returned = 0;
    logic [DEPTH_W-1:0]    last_depth = '0;
    logic                  quiet = 1'b0;
    logic [TIME_W-1:0]     cur_time = '0;
    logic [ITER_W-1:0]     cur_iter = '0;

    always #6 clk = ~clk;

    decimating_sample_fifo_recorder_unit uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_opcode(opcode), .i_time_us(time_us), .i_iteration(iteration),
        .i_sample_ok(sample_ok), .i_payload(payload), .i_stat_select(stat_select),
        .o_valid(res_valid), .o_status(status), .o_pop_valid(pop_valid),
        .o_pop_payload(pop_payload), .o_pop_time(pop_time),
        .o_pop_iteration(pop_iteration), .o_pop_dropped(pop_dropped),
        .o_depth(depth), .o_stat_value(stat_value), .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    dsfr_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_opcode(opcode), .i_time_us(time_us), .i_iteration(iteration),
        .i_sample_ok(sample_ok), .i_payload(payload), .i_stat_select(stat_select),
        .i_valid(res_valid), .i_status(status), .i_pop_valid(pop_valid),
        .i_pop_payload(pop_payload), .i_pop_time(pop_time),
        .i_pop_iteration(pop_iteration), .i_pop_dropped(pop_dropped),
        .i_depth(depth), .i_stat_value(stat_value), .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors)
    );

    always @(posedge clk) begin
        if (res_valid) begin
            returned <= returned + 1;
            last_depth <= depth;
        end
    end

    // caller is at a rising edge; leaves at the edge that took the item
    task automatic issue(t_op op, logic [TIME_W-1:0] t, logic [ITER_W-1:0] it,
                         logic ok, logic [PAYLOAD_W-1:0] pl, logic [2:0] sel);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start <= 1'b1;
        opcode <= op;
        time_us <= t;
        iteration <= it;
        sample_ok <= ok;
        payload <= pl;
        stat_select <= sel;
        issued++;
        do @(posedge clk); while (busy);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (returned != issued) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        settle();
        while (last_depth != 0) begin
            issue(OP_POP, '0, '0, 1'b0, '0, '0);
            settle();
        end
    endtask

    task automatic random_item(int pop_pct);
        int unsigned pick;
        logic [PAYLOAD_W-1:0] pl;
        pl = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < pop_pct) begin
            issue(OP_POP, $urandom, $urandom, 1'($urandom_range(0, 1)), pl, 3'($urandom));
        end else if (pick < pop_pct + 12) begin
            issue(OP_STAT, $urandom, $urandom, 1'($urandom_range(0, 1)), pl, 3'($urandom));
        end else if (pick < pop_pct + 15) begin
            issue(OP_NOP, $urandom, $urandom, 1'($urandom_range(0, 1)), pl, 3'($urandom));
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                issue(OP_CAPTURE, $urandom, $urandom, 1'($urandom_range(0, 1)), pl,
                      3'($urandom));
            end else if (pick < 12) begin
                issue(OP_CAPTURE, cur_time - $urandom_range(0, 3000),
                      cur_iter - $urandom_range(0, 2), 1'b1, pl, 3'($urandom));
            end else if (pick < 18) begin
                issue(OP_CAPTURE, cur_time, cur_iter, 1'b0, pl, 3'($urandom));
            end else begin
                cur_time = cur_time + ((pick < 22) ? $urandom_range(0, 1 << 20)
                                                   : $urandom_range(0, 9000));
                cur_iter = cur_iter + $urandom_range(0, 3);
                issue(OP_CAPTURE, cur_time, cur_iter, 1'b1, pl, 3'($urandom));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: inactive recorder, empty queue, stat selects, rate 3
        issue(OP_CAPTURE, '1, '1, 1'b1, '1, 3'd7);
        issue(OP_POP, '0, '0, 1'b0, '0, '0);
        issue(OP_NOP, '1, '1, 1'b1, '1, '1);
        for (int s = 0; s < 8; s++) issue(OP_STAT, '0, '0, 1'b0, '0, s[2:0]);
        write_reg(CFG_RATE, 2'd3);
        write_reg(CFG_ENABLE, 2'd1);
        issue(OP_CAPTURE, 32'd5, 32'd5, 1'b1, '0, '0);
        write_reg(CFG_RATE, RATE_1000);
        write_reg(CFG_ENABLE, 2'd1);
        issue(OP_CAPTURE, '0, '0, 1'b1, '0, '0);
        issue(OP_CAPTURE, 32'd999, 32'd1, 1'b1, '1, '0);
        issue(OP_CAPTURE, 32'd1000, 32'd2, 1'b0, '1, '0);
        issue(OP_CAPTURE, 32'd900, 32'd3, 1'b1, '1, '0);
        issue(OP_CAPTURE, 32'd1000, 32'd1, 1'b1, '1, '0);
        issue(OP_CAPTURE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 64'h8000_0000_0000_0001, '0);
        issue(OP_CAPTURE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0, '0);
        for (int s = 0; s < 7; s++) issue(OP_STAT, '0, '0, 1'b0, '0, s[2:0]);
        issue(OP_POP, '0, '0, 1'b0, '0, '0);
        // enable while running and with entries queued is ignored
        write_reg(CFG_ENABLE, 2'd1);
        write_reg(CFG_ENABLE, 2'd0);
        write_reg(CFG_RATE, RATE_250);
        write_reg(CFG_ENABLE, 2'd1);
        issue(OP_CAPTURE, 32'd1, 32'd1, 1'b1, '0, '0);
        issue(OP_STAT, '0, '0, 1'b0, '0, ST_ATTEMPTED);

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_ENABLE, 2'd0);
            if (ph != 5) drain();
            write_reg(CFG_RATE, (ph == 3) ? 2'd3 : 2'(ph % 3));
            write_reg(CFG_ENABLE, 2'd1);
            cur_time = (ph == 4) ? 32'hFFF0_0000 : $urandom_range(0, 1 << 16);
            cur_iter = (ph == 4) ? 32'hFFFF_FF00 : $urandom_range(0, 100);
            quiet = (ph == 7);
            for (int n = 0; n < ((ph == 2) ? 110 : 40); n++) begin
                random_item((ph == 2) ? 0 : 30);
            end
        end

        settle();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("status: fail");
        $finish;
    end

endmodule
